// File: hdl/fct_pkg.sv
// Package for the frustum cull tester: field widths, operation codes,
// controller state type and datapath command/status structs. No dependencies.
package fct_pkg;
   localparam int FracBits = 16;
   localparam int NumPlanes = 6;
   localparam int VecWidth = 32;
   localparam int CornerWidth = VecWidth + 1;
   localparam int ProdWidth = VecWidth + CornerWidth;
   localparam int DistWidth = ProdWidth + 3;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_POINT  = 2'd1,
      OP_SPHERE = 2'd2,
      OP_BOX    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       capture;
      logic       load;
      logic       mul;
      logic       sum;
      logic [2:0] corner;
   } cmd_type;

   typedef struct packed {
      logic pass;
   } status_type;
endpackage

// File: hdl/fct_ctrl.sv
// Controller of the frustum cull tester: sequences loads and the corner
// walk of the tests. Depends on fct_pkg.
module fct_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  fct_pkg::op_type     req_operation,
   input  fct_pkg::status_type status,
   output logic                busy,
   output fct_pkg::cmd_type    cmd,
   output logic                rsp_valid,
   output logic                rsp_visible
);
   import fct_pkg::*;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic [2:0] corner_ff, corner_in;
   logic      vis_ff, vis_in;
   logic      accept;

   assign accept = start && !busy;
   assign busy = (state_ff != ST_IDLE);

   // hold state, operation, corner count and running verdict
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         op_ff     <= OP_LOAD;
         corner_ff <= '0;
         vis_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         op_ff     <= op_in;
         corner_ff <= corner_in;
         vis_ff    <= vis_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      corner_in   = corner_ff;
      vis_in      = vis_ff;
      cmd         = '0;
      cmd.corner  = corner_ff;
      rsp_valid   = 1'b0;
      rsp_visible = vis_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in       = req_operation;
               corner_in   = '0;
               vis_in      = 1'b0;
               cmd.capture = 1'b1;
               if (req_operation == OP_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // fold this corner's verdict in, advance or finish
            vis_in = vis_ff || status.pass;
            if (op_ff == OP_BOX && corner_ff != 3'd7) begin
               corner_in = corner_ff + 3'd1;
               state_in  = ST_MUL;
            end else begin
               rsp_valid   = 1'b1;
               rsp_visible = vis_ff || status.pass;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

// File: hdl/fct_datapath.sv
// Datapath of the frustum cull tester: plane registers, corner formation
// and six plane evaluators. Depends on fct_pkg.
module fct_datapath (
   input  logic                          clock,
   input  fct_pkg::cmd_type              cmd,
   input  fct_pkg::op_type               req_operation,
   input  logic [2:0]                    req_plane_index,
   input  logic signed [fct_pkg::VecWidth-1:0] req_vec_x,
   input  logic signed [fct_pkg::VecWidth-1:0] req_vec_y,
   input  logic signed [fct_pkg::VecWidth-1:0] req_vec_z,
   input  logic signed [fct_pkg::VecWidth-1:0] req_vec_w,
   input  logic signed [fct_pkg::VecWidth-1:0] req_ext_x,
   input  logic signed [fct_pkg::VecWidth-1:0] req_ext_y,
   input  logic signed [fct_pkg::VecWidth-1:0] req_ext_z,
   output fct_pkg::status_type           status
);
   import fct_pkg::*;

   logic signed [VecWidth-1:0] pa_ff [NumPlanes];
   logic signed [VecWidth-1:0] pb_ff [NumPlanes];
   logic signed [VecWidth-1:0] pc_ff [NumPlanes];
   logic signed [VecWidth-1:0] pd_ff [NumPlanes];
   logic signed [VecWidth-1:0] cx_ff, cy_ff, cz_ff, cw_ff, ex_ff, ey_ff, ez_ff;
   logic                       sph_ff;
   logic                       is_box_ff;
   logic signed [CornerWidth-1:0] px, py, pz;
   logic signed [CornerWidth-1:0] bx, by, bz;
   logic signed [ProdWidth-1:0] mx_ff [NumPlanes];
   logic signed [ProdWidth-1:0] my_ff [NumPlanes];
   logic signed [ProdWidth-1:0] mz_ff [NumPlanes];
   logic signed [ProdWidth-1:0] md_ff [NumPlanes];
   logic [NumPlanes-1:0]       pos_ff;

   // write a plane on load (index below NumPlanes), capture operands on every accept
   always_ff @(posedge clock) begin
      if (cmd.load && req_plane_index < 3'(NumPlanes)) begin
         pa_ff[req_plane_index] <= req_vec_x;
         pb_ff[req_plane_index] <= req_vec_y;
         pc_ff[req_plane_index] <= req_vec_z;
         pd_ff[req_plane_index] <= req_vec_w;
      end
      if (cmd.capture) begin
         cx_ff     <= req_vec_x;
         cy_ff     <= req_vec_y;
         cz_ff     <= req_vec_z;
         cw_ff     <= req_vec_w;
         ex_ff     <= req_ext_x;
         ey_ff     <= req_ext_y;
         ez_ff     <= req_ext_z;
         sph_ff    <= (req_operation == OP_SPHERE);
         is_box_ff <= (req_operation == OP_BOX);
      end
   end

   // a point or sphere uses the centre itself
   always_comb begin
      px = CornerWidth'(cx_ff);
      py = CornerWidth'(cy_ff);
      pz = CornerWidth'(cz_ff);
   end

   // form the box corner selected by the controller
   always_comb begin
      bx = cmd.corner[0] ? CornerWidth'(cx_ff) + CornerWidth'(ex_ff)
                         : CornerWidth'(cx_ff) - CornerWidth'(ex_ff);
      by = cmd.corner[1] ? CornerWidth'(cy_ff) + CornerWidth'(ey_ff)
                         : CornerWidth'(cy_ff) - CornerWidth'(ey_ff);
      bz = cmd.corner[2] ? CornerWidth'(cz_ff) + CornerWidth'(ez_ff)
                         : CornerWidth'(cz_ff) - CornerWidth'(ez_ff);
   end

   // six evaluators: products, then sum and sign test
   for (genvar k = 0; k < NumPlanes; k++) begin : g_plane
      always_ff @(posedge clock) begin
         if (cmd.mul) begin
            mx_ff[k] <= ProdWidth'(pa_ff[k]) * ProdWidth'(is_box_ff ? bx : px);
            my_ff[k] <= ProdWidth'(pb_ff[k]) * ProdWidth'(is_box_ff ? by : py);
            mz_ff[k] <= ProdWidth'(pc_ff[k]) * ProdWidth'(is_box_ff ? bz : pz);
            md_ff[k] <= (ProdWidth'(pd_ff[k])
                         + (sph_ff ? ProdWidth'(cw_ff) : ProdWidth'(0))) <<< FracBits;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         for (int k = 0; k < NumPlanes; k++) begin
            pos_ff[k] <= (DistWidth'(mx_ff[k]) + DistWidth'(my_ff[k])
                          + DistWidth'(mz_ff[k]) + DistWidth'(md_ff[k])) > 0;
         end
      end
   end

   assign status.pass = &pos_ff;
endmodule

// File: hdl/frustum_cull_tester_top.sv
// Top level of the frustum cull tester: joins controller and datapath.
// Depends on fct_pkg, fct_ctrl, fct_datapath.
//
// A load is taken while idle and gives no result; the next transaction can
// be accepted at the very next edge. A point or sphere test steps through
// the multiply, sum and fold states (ST_MUL, ST_SUM, ST_DONE) and puts its
// rsp_valid strobe out in ST_DONE. A box test walks eight corners, each
// through multiply, sum and fold, and strobes in the fold of the last corner;
// the one set of six plane evaluators is reused for every corner. No new
// transaction is accepted until the current test has strobed its result.
// busy is high from acceptance through the result strobe;
// the result is shown for one cycle and cannot be stalled by the receiver.
module frustum_cull_tester_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_operation,
   input  logic [2:0]                    req_plane_index,
   input  logic signed [fct_pkg::VecWidth-1:0] req_vec_x,
   input  logic signed [fct_pkg::VecWidth-1:0] req_vec_y,
   input  logic signed [fct_pkg::VecWidth-1:0] req_vec_z,
   input  logic signed [fct_pkg::VecWidth-1:0] req_vec_w,
   input  logic signed [fct_pkg::VecWidth-1:0] req_ext_x,
   input  logic signed [fct_pkg::VecWidth-1:0] req_ext_y,
   input  logic signed [fct_pkg::VecWidth-1:0] req_ext_z,
   output logic                          rsp_valid,
   output logic                          rsp_visible
);
   import fct_pkg::*;

   cmd_type    cmd;
   status_type status;
   op_type     op;

   assign op = op_type'(req_operation);

   fct_ctrl u_ctrl (
      .clock, .reset, .start, .req_operation(op), .status, .busy, .cmd,
      .rsp_valid, .rsp_visible
   );

   fct_datapath u_dp (
      .clock, .cmd, .req_operation(op), .req_plane_index, .req_vec_x,
      .req_vec_y, .req_vec_z, .req_vec_w, .req_ext_x, .req_ext_y,
      .req_ext_z, .status
   );

   // a result never appears while idle
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result while idle");
   // a load never starts a walk
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == OP_LOAD) |=> !busy)
      else $error("load left block busy");
   // a test start makes the block busy
   a_test_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation != OP_LOAD) |=> busy)
      else $error("test did not start");
endmodule

// File: dv/tb_frustum_cull_tester_top.sv
// Self-checking testbench for frustum_cull_tester_top: loads planes, runs point,
// sphere and box tests and checks each visibility strobe against a built-in predictor.
// Depends on fct_pkg and the frustum_cull_tester_top RTL.
module tb_frustum_cull_tester_top;
   import fct_pkg::*;

   typedef struct {
      op_type          op;
      logic [2:0]      idx;
      logic signed [31:0] vx, vy, vz, vw, ex, ey, ez;
   } cull_txn_type;

   logic clock, reset, start, busy, rsp_valid, rsp_visible;
   logic [1:0] req_operation;
   logic [2:0] req_plane_index;
   logic signed [31:0] req_vec_x, req_vec_y, req_vec_z, req_vec_w;
   logic signed [31:0] req_ext_x, req_ext_y, req_ext_z;

   cull_txn_type pending_q[$];
   bit        visible_q[$];
   logic signed [31:0] planes [NumPlanes][4];
   int        mismatches = 0;
   int        cycles = 0;
   bit        stim_done = 0;
   bit        calm = 0;
   bit        one_vis;
   cull_txn_type t_next;

   frustum_cull_tester_top u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_plane_index(req_plane_index),
      .req_vec_x(req_vec_x), .req_vec_y(req_vec_y), .req_vec_z(req_vec_z),
      .req_vec_w(req_vec_w), .req_ext_x(req_ext_x), .req_ext_y(req_ext_y),
      .req_ext_z(req_ext_z), .rsp_valid(rsp_valid), .rsp_visible(rsp_visible)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // exact distance, scaled by 2^32
   function automatic logic signed [127:0] plane_distance(int k, logic signed [63:0] x,
         logic signed [63:0] y, logic signed [63:0] z);
      logic signed [127:0] s;
      s = 128'(planes[k][0]) * 128'(x) + 128'(planes[k][1]) * 128'(y)
        + 128'(planes[k][2]) * 128'(z) + (128'(planes[k][3]) <<< FracBits);
      return s;
   endfunction

   function automatic bit point_inside(logic signed [63:0] x, logic signed [63:0] y,
         logic signed [63:0] z);
      for (int k = 0; k < NumPlanes; k++)
         if (plane_distance(k, x, y, z) <= 0) return 0;
      return 1;
   endfunction

   // apply a transaction to the plane copy and return whether a strobe follows
   function automatic bit predict_visibility(cull_txn_type t, output bit vis);
      logic signed [63:0] x, y, z, px, py, pz;
      logic signed [127:0] rs;
      x = t.vx; y = t.vy; z = t.vz;
      vis = 0;
      case (t.op)
         OP_LOAD: begin
            if (t.idx < NumPlanes) begin
               planes[t.idx][0] = t.vx; planes[t.idx][1] = t.vy;
               planes[t.idx][2] = t.vz; planes[t.idx][3] = t.vw;
            end
            return 0;
         end
         OP_POINT: vis = point_inside(x, y, z);
         OP_SPHERE: begin
            rs = 128'(t.vw) <<< FracBits;
            vis = 1;
            for (int k = 0; k < NumPlanes; k++)
               if (plane_distance(k, x, y, z) + rs <= 0) vis = 0;
         end
         default: begin
            for (int c = 0; c < 8; c++) begin
               px = c[0] ? x + t.ex : x - t.ex;
               py = c[1] ? y + t.ey : y - t.ey;
               pz = c[2] ? z + t.ez : z - t.ez;
               if (point_inside(px, py, pz)) vis = 1;
            end
         end
      endcase
      return 1;
   endfunction

   function automatic logic signed [31:0] rand_q(bit near);
      case ($urandom_range(0, 5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $urandom;
         default: return near ? 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16))
                              : 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
      endcase
   endfunction

   function automatic cull_txn_type make_load(int idx, logic signed [31:0] a,
         logic signed [31:0] b, logic signed [31:0] c, logic signed [31:0] d);
      cull_txn_type t;
      t.op = OP_LOAD; t.idx = 3'(idx);
      t.vx = a; t.vy = b; t.vz = c; t.vw = d;
      t.ex = $urandom; t.ey = $urandom; t.ez = $urandom;
      return t;
   endfunction

   function automatic cull_txn_type make_test(op_type op, logic signed [31:0] x,
         logic signed [31:0] y, logic signed [31:0] z, logic signed [31:0] w,
         logic signed [31:0] ex, logic signed [31:0] ey, logic signed [31:0] ez);
      cull_txn_type t;
      t.op = op; t.idx = 3'($urandom); t.vx = x; t.vy = y; t.vz = z; t.vw = w;
      t.ex = ex; t.ey = ey; t.ez = ez;
      return t;
   endfunction

   // fill the queue: a cube frustum of half-width 10, extremes, then random traffic
   initial begin
      cull_txn_type t;
      int one;
      one = 1 << FracBits;
      pending_q.push_back(make_load(0, one, 0, 0, 10 * one));
      pending_q.push_back(make_load(1, -one, 0, 0, 10 * one));
      pending_q.push_back(make_load(2, 0, one, 0, 10 * one));
      pending_q.push_back(make_load(3, 0, -one, 0, 10 * one));
      pending_q.push_back(make_load(4, 0, 0, one, 10 * one));
      pending_q.push_back(make_load(5, 0, 0, -one, 10 * one));
      pending_q.push_back(make_load(6, 1, 2, 3, 4));
      pending_q.push_back(make_load(7, -1, -2, -3, -4));
      pending_q.push_back(make_test(OP_POINT, 0, 0, 0, 0, 0, 0, 0));
      pending_q.push_back(make_test(OP_POINT, 10 * one, 0, 0, 0, 0, 0, 0));
      pending_q.push_back(make_test(OP_POINT, 32'sh7fffffff, 32'sh80000000, 0, 0, 0, 0, 0));
      pending_q.push_back(make_test(OP_SPHERE, 12 * one, 0, 0, 2 * one, 0, 0, 0));
      pending_q.push_back(make_test(OP_SPHERE, 13 * one, 0, 0, 2 * one, 0, 0, 0));
      pending_q.push_back(make_test(OP_SPHERE, 0, 0, 0, -20 * one, 0, 0, 0));
      pending_q.push_back(make_test(OP_SPHERE, 0, 0, 0, 32'sh80000000, 0, 0, 0));
      pending_q.push_back(make_test(OP_BOX, 20 * one, 0, 0, 0, 15 * one, one, one));
      pending_q.push_back(make_test(OP_BOX, 20 * one, 0, 0, 0, -15 * one, one, one));
      pending_q.push_back(make_test(OP_BOX, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0,
                                    32'sh80000000, 32'sh7fffffff, 32'sh80000000));
      pending_q.push_back(make_load(0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                                    32'sh80000000));
      pending_q.push_back(make_test(OP_POINT, 32'sh80000000, 32'sh7fffffff, -1, 0, 0, 0, 0));
      pending_q.push_back(make_test(OP_BOX, -1, -1, -1, -1, -1, -1, -1));
      for (int i = 0; i < 1700; i++) begin
         if ($urandom_range(0, 9) == 0)
            t = make_load($urandom_range(0, 7), rand_q(0), rand_q(0), rand_q(0),
                          rand_q(1));
         else
            t = make_test(op_type'($urandom_range(1, 3)), rand_q(1), rand_q(1), rand_q(1),
                          rand_q(1), rand_q(1), rand_q(1), rand_q(1));
         pending_q.push_back(t);
      end
   end

   // driver: hold start until accepted, then advance
   always @(posedge clock) begin
      cycles <= cycles + 1;
      calm <= (cycles > 4000 && cycles < 8000);
      if (reset) begin
         start <= 0;
      end else begin
         if (start && !busy) begin
            if (predict_visibility(pending_q[0], one_vis)) visible_q.push_back(one_vis);
            void'(pending_q.pop_front());
         end
         if ((start && busy) || (pending_q.size() > 0
               && (calm || $urandom_range(0, 99) >= 37))) begin
            t_next = pending_q[0];
            start <= 1;
            req_operation <= t_next.op; req_plane_index <= t_next.idx;
            req_vec_x <= t_next.vx; req_vec_y <= t_next.vy;
            req_vec_z <= t_next.vz; req_vec_w <= t_next.vw;
            req_ext_x <= t_next.ex; req_ext_y <= t_next.ey; req_ext_z <= t_next.ez;
         end else begin
            start <= 0;
            if (pending_q.size() == 0 && cycles > 100) stim_done <= 1;
         end
      end
   end

   // monitor: compare each strobe with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (visible_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result visible=%0b", rsp_visible);
         end else begin
            if (rsp_visible !== visible_q[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("visible mismatch: expected %0b actual %0b", visible_q[0],
                           rsp_visible);
            end
            void'(visible_q.pop_front());
         end
      end
   end

   initial begin
      reset = 1; start = 0;
      req_operation = '0; req_plane_index = '0;
      req_vec_x = '0; req_vec_y = '0; req_vec_z = '0; req_vec_w = '0;
      req_ext_x = '0; req_ext_y = '0; req_ext_z = '0;
      repeat (11) @(posedge clock);
      reset <= 0;
      while (!(stim_done && visible_q.size() == 0) && cycles < 400000) @(posedge clock);
      repeat (40) @(posedge clock);
      if (cycles >= 400000 || visible_q.size() != 0) begin
         $display("[frustum_cull_tester_top] ERROR");
      end else if (mismatches == 0) begin
         $display("[frustum_cull_tester_top] OK");
      end else begin
         $display("[frustum_cull_tester_top] ERROR");
      end
      $finish;
   end
endmodule

// File: filelist.f
hdl/fct_pkg.sv
hdl/fct_ctrl.sv
hdl/fct_datapath.sv
hdl/frustum_cull_tester_top.sv
dv/tb_frustum_cull_tester_top.sv
